// ===== rtl/tpom_pkg.sv =====
`default_nettype none
package tpom_pkg;
	localparam int TAPS = 12;
	localparam int PHASES = 4;
	localparam int COEF_SHIFT = 13;
	localparam int PEAK_BITS = 50;
	localparam int COEF_BITS = 14;
	localparam int TAP_IDX_BITS = 4;
	localparam int PHASE_IDX_BITS = 2;

	function automatic logic signed [COEF_BITS-1:0] coef(input logic [PHASE_IDX_BITS-1:0] p,
		input logic [TAP_IDX_BITS-1:0] k);
		int c;
		c = 0;
		case ({p, k})
			6'h00: c = 14;    6'h01: c = 90;    6'h02: c = -161;  6'h03: c = 272;
			6'h04: c = -487;  6'h05: c = 1125;  6'h06: c = 7964;  6'h07: c = -838;
			6'h08: c = 390;   6'h09: c = -218;  6'h0a: c = 122;   6'h0b: c = -68;
			6'h10: c = -239;  6'h11: c = 240;   6'h12: c = -424;  6'h13: c = 730;
			6'h14: c = -1364; 6'h15: c = 3810;  6'h16: c = 6388;  6'h17: c = -1641;
			6'h18: c = 832;   6'h19: c = -477;  6'h1a: c = 271;   6'h1b: c = -155;
			6'h20: c = -155;  6'h21: c = 271;   6'h22: c = -477;  6'h23: c = 832;
			6'h24: c = -1641; 6'h25: c = 6388;  6'h26: c = 3810;  6'h27: c = -1364;
			6'h28: c = 730;   6'h29: c = -424;  6'h2a: c = 240;   6'h2b: c = -239;
			6'h30: c = -68;   6'h31: c = 122;   6'h32: c = -218;  6'h33: c = 390;
			6'h34: c = -838;  6'h35: c = 7964;  6'h36: c = 1125;  6'h37: c = -487;
			6'h38: c = 272;   6'h39: c = -161;  6'h3a: c = 90;    6'h3b: c = 14;
			default: c = 0;
		endcase
		return COEF_BITS'(c);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/tpom_tap_cell.sv =====
`default_nettype none
// One delay-line cell per channel pair: shift on load, rotate during compute.
module tpom_tap_cell #(
	parameter int W = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic                rotate,
	input  wire logic signed [W-1:0] l_in,
	input  wire logic signed [W-1:0] r_in,
	output logic signed [W-1:0]      l_q,
	output logic signed [W-1:0]      r_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q <= '0;
			r_q <= '0;
		end else if (load || rotate) begin
			l_q <= l_in;
			r_q <= r_in;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tpom_mac.sv =====
`default_nettype none
// Shared multiply-accumulate, floor shift, square, saturate.
module tpom_mac #(
	parameter int W = 24
) (
	input  wire logic                  clk,
	input  wire logic signed [W-1:0]   smp,
	input  wire logic signed [tpom_pkg::COEF_BITS-1:0] cf,
	input  wire logic                  first,
	input  wire logic                  mac_en,
	output logic [tpom_pkg::PEAK_BITS-1:0] sq
);
	localparam int AW = W + tpom_pkg::COEF_BITS + 4;
	localparam int HB = tpom_pkg::PEAK_BITS / 2;
	logic signed [W+tpom_pkg::COEF_BITS-1:0] prod;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] shifted;
	logic [AW-1:0] mag;
	logic [2*HB-1:0] mag_sq;
	assign prod = smp * cf;
	always_ff @(posedge clk) begin
		if (mac_en)
			acc_q <= (first ? AW'(0) : acc_q) + AW'(prod);
	end
	always_comb begin
		shifted = acc_q >>> tpom_pkg::COEF_SHIFT;
		mag = shifted[AW-1] ? AW'(-shifted) : AW'(shifted);
		mag_sq = mag[HB-1:0] * mag[HB-1:0];
		if (mag >= (AW'(1) << HB))
			sq = '1;
		else
			sq = mag_sq[tpom_pkg::PEAK_BITS-1:0];
	end
endmodule
`default_nettype wire

// ===== rtl/true_peak_oversampling_meter_core.sv =====
`default_nettype none
// channel | signals                                         | direction
// in      | in_valid in_stall left_sample right_sample last_of_block | to block
// out     | out_valid out_stall peak_square                 | from block
// An item is loaded on accept, then runs 96 MAC steps (2 channels x 4 phases
// x 12 taps on one multiplier, delay-line cells rotating), plus one compare.
// The result word sits in an output register; the next item is taken only
// after it leaves.
// Reset clears the cells, the peak and the sequencer.
// A stalled result holds until taken.
module true_peak_oversampling_meter_core #(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] left_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] right_sample,
	input  wire logic                         last_of_block,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [tpom_pkg::PEAK_BITS-1:0]    peak_square
);
	localparam int T = tpom_pkg::TAPS;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [tpom_pkg::TAP_IDX_BITS-1:0] tap_q;
	logic [tpom_pkg::PHASE_IDX_BITS-1:0] ph_q;
	logic chan_q, last_q, step_q;
	logic [tpom_pkg::PEAK_BITS-1:0] peak_q;
	logic [tpom_pkg::PEAK_BITS-1:0] peak_next;
	logic signed [SAMPLE_BITS-1:0] lc [T];
	logic signed [SAMPLE_BITS-1:0] rc [T];
	logic [tpom_pkg::PEAK_BITS-1:0] sq;
	logic accept, load, rotate, done_step;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign load = accept;
	// rotate the channel ring being read, 12 steps per phase bring it back
	assign rotate = (state_q == ST_RUN);

	// cell 0 is the newest sample; data walks toward cell T-1
	for (genvar i = 0; i < T; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] l_in, r_in;
		always_comb begin
			if (load) begin
				l_in = (i == 0) ? left_sample : lc[(i+T-1)%T];
				r_in = (i == 0) ? right_sample : rc[(i+T-1)%T];
			end else begin
				l_in = chan_q ? lc[i] : lc[(i+1)%T];
				r_in = chan_q ? rc[(i+1)%T] : rc[i];
			end
		end
		tpom_tap_cell #(.W(SAMPLE_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n), .load(load), .rotate(rotate),
			.l_in(l_in), .r_in(r_in), .l_q(lc[i]), .r_q(rc[i])
		);
	end

	tpom_mac #(.W(SAMPLE_BITS)) u_mac (
		.clk(clk),
		.smp(chan_q ? rc[0] : lc[0]),
		.cf(tpom_pkg::coef(ph_q, tap_q)),
		.first(tap_q == '0),
		.mac_en(rotate),
		.sq(sq)
	);

	assign done_step = rotate && (tap_q == 4'(T-1)) && chan_q && (ph_q == 2'(tpom_pkg::PHASES-1));

	// fold the square of the sum just closed
	assign peak_next = (step_q && sq > peak_q) ? sq : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q <= '0;
			ph_q <= '0;
			chan_q <= 1'b0;
			last_q <= 1'b0;
			step_q <= 1'b0;
			peak_q <= '0;
			out_valid <= 1'b0;
			peak_square <= '0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			step_q <= rotate && (tap_q == 4'(T-1));
			// drop the peak once the block's result is latched into the output register
			if (state_q == ST_DONE && last_q)
				peak_q <= '0;
			else
				peak_q <= peak_next;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						last_q <= last_of_block;
						tap_q <= '0;
						ph_q <= '0;
						chan_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (tap_q == 4'(T-1)) begin
						tap_q <= '0;
						chan_q <= !chan_q;
						if (chan_q)
							ph_q <= ph_q + 1'b1;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
					if (done_step)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					if (last_q) begin
						out_valid <= 1'b1;
						peak_square <= peak_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("accept while busy");
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN)) else $error("accept did not start run");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(peak_square))
		else $error("result dropped");
	a_peak_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (peak_q == '0)) else $error("peak not cleared");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
	localparam int SB = 24;
	localparam int TAPS = tpom_pkg::TAPS;
	localparam int PHASES = tpom_pkg::PHASES;
	localparam int PEAK_BITS = tpom_pkg::PEAK_BITS;
	localparam int COEF_SHIFT = tpom_pkg::COEF_SHIFT;
	localparam logic [PEAK_BITS-1:0] PEAK_SAT = {PEAK_BITS{1'b1}};
	localparam int IDLE_LIMIT = 20000;
	localparam int DIRECTED_ROWS = 14;

	// One row of the directed table: the word to send and, where it is plain, the peak.
	typedef struct {
		logic signed [SB-1:0] left;
		logic signed [SB-1:0] right;
		logic last;
		bit known;
		logic [PEAK_BITS-1:0] peak;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SB-1:0] left_sample = '0;
	logic signed [SB-1:0] right_sample = '0;
	logic last_of_block = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PEAK_BITS-1:0] peak_square;

	always #4 clk = ~clk;

	true_peak_oversampling_meter_core #(.SAMPLE_BITS(SB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_sample(left_sample), .right_sample(right_sample),
		.last_of_block(last_of_block),
		.out_valid(out_valid), .out_stall(out_stall), .peak_square(peak_square)
	);

	// Predictor state: delay lines with the newest sample at slot pos.
	logic signed [SB-1:0] left_line [TAPS];
	logic signed [SB-1:0] right_line [TAPS];
	int unsigned pos = 0;
	logic [PEAK_BITS-1:0] block_peak = '0;
	logic [PEAK_BITS-1:0] peak_queue [$];

	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	stim_row_t rows [DIRECTED_ROWS];

	// Tap weights per phase: the filter coefficients times 8192, as integers.
	int weight [PHASES][TAPS] = '{
		'{14, 90, -161, 272, -487, 1125, 7964, -838, 390, -218, 122, -68},
		'{-239, 240, -424, 730, -1364, 3810, 6388, -1641, 832, -477, 271, -155},
		'{-155, 271, -477, 832, -1641, 6388, 3810, -1364, 730, -424, 240, -239},
		'{-68, 122, -218, 390, -838, 7964, 1125, -487, 272, -161, 90, 14}
	};

	// Filter one line in one phase, floor-shift by 13, square, saturate.
	function automatic logic [PEAK_BITS-1:0] phase_power(input bit use_right,
		input int ph);
		longint acc;
		longint mag;
		acc = 0;
		for (int k = 0; k < TAPS; k++)
			acc += longint'(use_right ? right_line[(pos + k) % TAPS]
				: left_line[(pos + k) % TAPS]) * weight[ph][k];
		mag = acc >>> COEF_SHIFT;
		if (mag < 0)
			mag = -mag;
		if (mag >= (longint'(1) << (PEAK_BITS / 2)))
			return PEAK_SAT;
		return PEAK_BITS'(mag * mag);
	endfunction

	// Advance the predictor by one accepted word; queue the peak on a last word.
	task automatic predict_word(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
		input logic last);
		logic [PEAK_BITS-1:0] v;
		pos = (pos == 0) ? TAPS - 1 : pos - 1;
		left_line[pos] = l;
		right_line[pos] = r;
		for (int p = 0; p < PHASES; p++) begin
			v = phase_power(1'b0, p);
			if (v > block_peak)
				block_peak = v;
			v = phase_power(1'b1, p);
			if (v > block_peak)
				block_peak = v;
		end
		if (last) begin
			peak_queue.push_back(block_peak);
			block_peak = '0;
		end
	endtask

	// Compare each result word against the oldest pending peak.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (peak_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result peak_square=%0h", peak_square);
			end else begin
				if (peak_square !== peak_queue[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("peak_square mismatch exp=%0h act=%0h",
							peak_queue[0], peak_square);
				end
				void'(peak_queue.pop_front());
			end
		end
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Watchdog: count cycles with nothing accepted on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Drive one word and hold it until accepted; gaps are drawn before it.
	task automatic send_word(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
		input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		last_of_block <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_word(l, r, last);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'sh7fffff;
			1: return 24'sh800000;
			2: return SB'($urandom_range(255)) - 128;
			default: return SB'($urandom);
		endcase
	endfunction

	initial begin
		stim_row_t row;
		int sent;
		int block_len;
		foreach (left_line[i]) begin
			left_line[i] = '0;
			right_line[i] = '0;
		end
		// Directed rows: reset peak, full-scale extremes, single-channel cases.
		rows[0] = '{'0, '0, 1'b1, 1'b1, '0};
		rows[1] = '{'0, '0, 1'b1, 1'b1, '0};
		rows[2] = '{24'sh7fffff, '0, 1'b0, 1'b0, '0};
		rows[3] = '{'0, '0, 1'b1, 1'b0, '0};
		rows[4] = '{'0, 24'sh800000, 1'b1, 1'b0, '0};
		rows[5] = '{24'sh800000, 24'sh7fffff, 1'b0, 1'b0, '0};
		rows[6] = '{24'sh7fffff, 24'sh800000, 1'b0, 1'b0, '0};
		rows[7] = '{24'sh800000, 24'sh7fffff, 1'b1, 1'b0, '0};
		rows[8] = '{-24'sd1, -24'sd1, 1'b1, 1'b0, '0};
		rows[9] = '{24'sd1, -24'sd1, 1'b1, 1'b0, '0};
		rows[10] = '{24'sh555555, 24'shaaaaaa, 1'b0, 1'b0, '0};
		rows[11] = '{24'shaaaaaa, 24'sh555555, 1'b1, 1'b0, '0};
		rows[12] = '{'0, '0, 1'b0, 1'b0, '0};
		rows[13] = '{'0, '0, 1'b1, 1'b0, '0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the table; a typed-in peak must match what the predictor queues.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = rows[i];
			send_word(row.left, row.right, row.last);
			if (row.known && row.last && peak_queue[$] !== row.peak) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d peak exp=%0h pred=%0h", i, row.peak,
						peak_queue[$]);
			end
		end
		drop_valid();

		// Random blocks over three idling phases; blocks mostly short.
		sent = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 55 : 0;
			recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 28 : 0;
			while (sent < 370 * (ph + 1)) begin
				block_len = ($urandom_range(9) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 12);
				for (int j = 0; j < block_len; j++) begin
					send_word(rand_sample(), rand_sample(), j == block_len - 1);
					sent++;
				end
			end
			// Hold off until every pending peak has come back.
			drop_valid();
			while (peak_queue.size() != 0)
				@(posedge clk);
		end
		drop_valid();

		while (peak_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/tpom_pkg.sv
rtl/tpom_tap_cell.sv
rtl/tpom_mac.sv
rtl/true_peak_oversampling_meter_core.sv
dv/tb_top.sv
